// ===== hw/rtl/modular_inverse_64_top_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef MODULAR_INVERSE_64_TOP_MACROS_SVH
`define MODULAR_INVERSE_64_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define MI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mi_pkg.sv =====
`default_nettype none

package mi_pkg;

  localparam int FIELD_BITS    = 64;
  localparam int WORD_BITS_DEF = 64;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mi_div.sv =====
`default_nettype none

// shift-subtract divider, one quotient bit per cycle, msb first
// also accumulates quotient * coef modulo 2^WORD_BITS alongside
module mi_div #(
  parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mi_pkg::div_ctl_t      ctl_i,
  input  wire logic [WORD_BITS-1:0]  num_i,
  input  wire logic [WORD_BITS-1:0]  den_i,
  input  wire logic [WORD_BITS-1:0]  coef_i,
  output mi_pkg::div_sts_t           sts_o,
  output logic      [WORD_BITS-1:0]  rem_o,
  output logic      [WORD_BITS-1:0]  prod_o
);

  localparam int W    = WORD_BITS;
  localparam int CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    num_q, num_d;
  logic [W-1:0]    den_q, den_d;
  logic [W-1:0]    coef_q, coef_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    prod_q, prod_d;

  logic [W:0]      shifted;
  logic [W+1:0]    diff;
  logic            ge;

  always_comb begin
    shifted = {rem_q, num_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = ~diff[W+1];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    coef_d = coef_q;
    rem_d  = rem_q;
    prod_d = prod_q;

    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W - 1);
      num_d  = num_i;
      den_d  = den_i;
      coef_d = coef_i;
      rem_d  = '0;
      prod_d = '0;
    end else if (busy_q) begin
      num_d  = {num_q[W-2:0], 1'b0};
      rem_d  = ge ? diff[W-1:0] : shifted[W-1:0];
      prod_d = {prod_q[W-2:0], 1'b0} + (ge ? coef_q : '0);
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    coef_q <= coef_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;
  assign prod_o     = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/modular_inverse_64_top.sv =====
// Modular inverse by the extended Euclidean algorithm, one item at a time. After a transfer
// in, in_stall_o stays high until the item is done. Setup runs through S_INIT, S_L1 and S_L2;
// each Euclid step with quotient 1 to 3 takes a loop check in S_MAIN plus the subtract path
// (S_SMA, then S_SMB), and each larger quotient goes to the shift-subtract divider (S_DIV,
// then S_DIVFIN). The unit passes back through idle before the next transfer in. For random
// 64-bit operands the divisions dominate. The result sits in an output register, so the next
// item can be taken while it waits for its transfer out. A gcd other than one is not
// flagged; a zero value gives zero.
`default_nettype none

`include "modular_inverse_64_top_macros.svh"

module modular_inverse_64_top #(
  parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mi_pkg::FIELD_BITS-1:0] value_i,
  input  wire logic [mi_pkg::FIELD_BITS-1:0] modulus_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mi_pkg::FIELD_BITS-1:0] inverse_o
);

  localparam int W = WORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_L1,
    S_L2,
    S_MAIN,
    S_SMA,
    S_SMB,
    S_DIV,
    S_DIVFIN,
    S_FIX
  } state_e;

  state_e state_q, state_d;
  state_e phase_q, phase_d;
  logic   ov_q, ov_d;
  logic [W-1:0] inv_q, inv_d;

  logic [W-1:0] a_q, a_d;
  logic [W-1:0] b_q, b_d;
  logic [W-1:0] c1_q, c1_d;
  logic [W-1:0] c2_q, c2_d;
  logic [W-1:0] y_q, y_d;
  logic [W-1:0] d_q, d_d;
  logic [W-1:0] e1_q, e1_d;
  logic         top_q, top_d;

  logic [W-1:0] x_in, y_in;
  logic [W-1:0] b2, b4, c2x2;
  logic         lt1, lt2;
  logic [W-1:0] sub_b, sub_c;
  logic         out_free;

  mi_pkg::div_ctl_t div_ctl;
  mi_pkg::div_sts_t div_sts;
  logic [W-1:0]     div_rem;
  logic [W-1:0]     div_prod;

  mi_div #(
    .WORD_BITS(W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (a_q),
    .den_i  (b_q),
    .coef_i (c2_q),
    .sts_o  (div_sts),
    .rem_o  (div_rem),
    .prod_o (div_prod)
  );

  always_comb begin
    x_in  = value_i[W-1:0];
    y_in  = modulus_i[W-1:0];
    b2    = {b_q[W-2:0], 1'b0};
    b4    = {b_q[W-3:0], 2'b00};
    c2x2  = {c2_q[W-2:0], 1'b0};
    lt1   = d_q < b_q;
    lt2   = d_q < b2;
    // quotient 1, 2 or 3 picks how much more to take off
    sub_b = lt1 ? '0 : (lt2 ? b_q : b2);
    sub_c = lt1 ? '0 : (lt2 ? c2_q : c2x2);
    out_free = !ov_q || !out_stall_i;

    state_d = state_q;
    phase_d = phase_q;
    ov_d    = ov_q;
    inv_d   = inv_q;
    a_d     = a_q;
    b_d     = b_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    y_d     = y_q;
    d_d     = d_q;
    e1_d    = e1_q;
    top_d   = top_q;
    div_ctl.start = 1'b0;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          y_d   = y_in;
          top_d = x_in[W-1] & y_in[W-1];
          if (x_in > y_in) begin
            a_d  = x_in;
            b_d  = y_in;
            c1_d = W'(1);
            c2_d = '0;
          end else begin
            a_d  = y_in;
            b_d  = x_in;
            c1_d = '0;
            c2_d = W'(1);
          end
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        // both top bits set: one subtract step up front
        if (top_q) begin
          a_d  = b_q;
          b_d  = a_q - b_q;
          c1_d = c2_q;
          c2_d = c1_q - c2_q;
        end
        state_d = S_L1;
      end
      S_L1: begin
        if (b_q[W-2] && !b_q[W-1]) begin
          phase_d = S_L1;
          state_d = S_SMA;
        end else begin
          state_d = S_L2;
        end
      end
      S_L2: begin
        if (b_q[W-1]) begin
          phase_d = S_L2;
          state_d = S_SMA;
        end else begin
          state_d = S_MAIN;
        end
      end
      S_MAIN: begin
        if (b_q == '0) begin
          state_d = S_FIX;
        end else if (a_q < b4 && b_q[W-1:W-2] == 2'b00) begin
          phase_d = S_MAIN;
          state_d = S_SMA;
        end else begin
          div_ctl.start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_SMA: begin
        d_d     = a_q - b_q;
        e1_d    = c1_q - c2_q;
        state_d = S_SMB;
      end
      S_SMB: begin
        a_d     = b_q;
        b_d     = d_q - sub_b;
        c1_d    = c2_q;
        c2_d    = e1_q - sub_c;
        state_d = phase_q;
      end
      S_DIV: begin
        if (div_sts.done) state_d = S_DIVFIN;
      end
      S_DIVFIN: begin
        a_d     = b_q;
        b_d     = div_rem;
        c1_d    = c2_q;
        c2_d    = c1_q - div_prod;
        state_d = S_MAIN;
      end
      S_FIX: begin
        if (out_free) begin
          inv_d   = c1_q[W-1] ? c1_q + y_q : c1_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= S_L1;
      ov_q    <= 1'b0;
      inv_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ov_q    <= ov_d;
      inv_q   <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c1_q  <= c1_d;
    c2_q  <= c2_d;
    y_q   <= y_d;
    d_q   <= d_d;
    e1_q  <= e1_d;
    top_q <= top_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign inverse_o   = mi_pkg::FIELD_BITS'(inv_q);

  `MI_ASSERT(a_div_start, div_ctl.start |-> (state_q == S_MAIN && b_q != '0), "bad divider start")
  `MI_ASSERT(a_div_owner, (div_sts.busy || div_sts.done) |-> state_q == S_DIV, "stray divider")
  `MI_ASSERT(a_rem_lt, (state_q == S_DIVFIN) |-> (div_rem < b_q), "remainder not below divisor")
  `MI_ASSERT_NEXT(a_accept, in_valid_i && !in_stall_o, state_q == S_INIT, "setup not started")

endmodule

`default_nettype wire
